@@ hw/rtl/sgmg_pkg.sv @@
// Shared types, widths and codes of the structured grid mesh generator.
package sgmg_pkg;

	localparam int CW  = 11;
	localparam int RW  = CW + 1;
	localparam int PW  = 2 * RW;
	localparam int EW  = 2 * CW;
	localparam int NW  = 31;
	localparam int XW  = 42;
	localparam int VW  = 48;
	localparam int SW  = 32;
	localparam int DW  = 64;
	localparam int IW  = 3;
	localparam int SLW = 3;
	localparam int HW  = 2;

	localparam logic [CW-1:0] MAX_CELLS = CW'(1024);

	localparam logic [IW-1:0] REG_DIMENSION = 3'd0;
	localparam logic [IW-1:0] REG_CELLS_X   = 3'd1;
	localparam logic [IW-1:0] REG_CELLS_Y   = 3'd2;
	localparam logic [IW-1:0] REG_CELLS_Z   = 3'd3;
	localparam logic [IW-1:0] REG_SPACING_X = 3'd4;
	localparam logic [IW-1:0] REG_SPACING_Y = 3'd5;
	localparam logic [IW-1:0] REG_SPACING_Z = 3'd6;

	localparam logic [1:0] DIM_LINE = 2'd1;
	localparam logic [1:0] DIM_QUAD = 2'd2;
	localparam logic [1:0] DIM_HEX  = 2'd3;

	localparam logic OP_NODE    = 1'b0;
	localparam logic OP_ELEMENT = 1'b1;

	typedef struct packed {
		logic [1:0]    dim;
		logic [CW-1:0] nx;
		logic [CW-1:0] ny;
		logic [CW-1:0] nz;
		logic [RW-1:0] row;
		logic [PW-1:0] plane;
		logic [EW-1:0] elem_plane;
		logic [SW-1:0] sx;
		logic [SW-1:0] sy;
		logic [SW-1:0] sz;
		logic [DW-1:0] sxsy;
		logic [DW-1:0] top;
	} sgmg_cfg_t;

	typedef struct packed {
		logic          err;
		logic          op;
		logic [NW-1:0] base;
		logic [NW-1:0] elem;
		logic [XW-1:0] px;
		logic [XW-1:0] py;
		logic [XW-1:0] pz;
		logic [VW-1:0] vol;
	} sgmg_item_t;

	typedef struct packed {
		logic           error;
		logic [NW-1:0]  item_number;
		logic [SLW-1:0] vertex_slot;
		logic [NW-1:0]  node_index;
		logic [XW-1:0]  pos_x;
		logic [XW-1:0]  pos_y;
		logic [XW-1:0]  pos_z;
		logic [VW-1:0]  volume;
		logic           last;
	} sgmg_beat_t;

	function automatic logic [CW-1:0] eff_cells(input logic [CW-1:0] c);
		logic [CW-1:0] r;
		if (c == '0) begin
			r = CW'(1);
		end else if (c > MAX_CELLS) begin
			r = MAX_CELLS;
		end else begin
			r = c;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/sgmg_cfg.sv @@
// Configuration registers and the grid constants derived from them.
module sgmg_cfg import sgmg_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_index,
	input  logic [SW-1:0] wr_data,
	output sgmg_cfg_t     cfg
);

	logic [1:0]    dim_q;
	logic [CW-1:0] cx_q;
	logic [CW-1:0] cy_q;
	logic [CW-1:0] cz_q;
	logic [SW-1:0] sx_q;
	logic [SW-1:0] sy_q;
	logic [SW-1:0] sz_q;

	logic [RW-1:0] row_q;
	logic [PW-1:0] plane_q;
	logic [EW-1:0] ep_q;
	logic [DW-1:0] sxsy_q;
	logic [DW-1:0] lo_q;
	logic [DW-1:0] hi_q;
	logic [DW-1:0] top_q;

	logic [1:0]    dim_e;
	logic [CW-1:0] nx;
	logic [CW-1:0] ny;
	logic [CW-1:0] nz;
	logic [CW-1:0] ny_e;

	always_comb begin
		dim_e = (dim_q == 2'd0) ? DIM_LINE : dim_q;
		nx    = eff_cells(cx_q);
		ny    = (dim_e >= DIM_QUAD) ? eff_cells(cy_q) : '0;
		nz    = (dim_e == DIM_HEX) ? eff_cells(cz_q) : '0;
		ny_e  = (dim_e >= DIM_QUAD) ? ny : CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_QUAD;
			cx_q  <= CW'(1);
			cy_q  <= CW'(1);
			cz_q  <= CW'(1);
			sx_q  <= SW'(65536);
			sy_q  <= SW'(65536);
			sz_q  <= SW'(65536);
		end else if (wr_en) begin
			case (wr_index)
				REG_DIMENSION: dim_q <= wr_data[1:0];
				REG_CELLS_X:   cx_q  <= wr_data[CW-1:0];
				REG_CELLS_Y:   cy_q  <= wr_data[CW-1:0];
				REG_CELLS_Z:   cz_q  <= wr_data[CW-1:0];
				REG_SPACING_X: sx_q  <= wr_data;
				REG_SPACING_Y: sy_q  <= wr_data;
				REG_SPACING_Z: sz_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// derived constants; top is via sxsy_q, lo_q and hi_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= RW'(2);
			plane_q <= PW'(4);
			ep_q    <= EW'(1);
			sxsy_q  <= DW'(64'h1_0000_0000);
			lo_q    <= '0;
			hi_q    <= DW'(65536);
			top_q   <= DW'(65536);
		end else begin
			row_q   <= RW'(nx) + RW'(1);
			plane_q <= (PW'(nx) + PW'(1)) * (PW'(ny) + PW'(1));
			ep_q    <= EW'(nx) * EW'(ny_e);
			sxsy_q  <= DW'(sx_q) * DW'(sy_q);
			lo_q    <= DW'(sxsy_q[SW-1:0]) * DW'(sz_q);
			hi_q    <= DW'(sxsy_q[DW-1:SW]) * DW'(sz_q);
			top_q   <= hi_q + DW'(lo_q[DW-1:SW]);
		end
	end

	always_comb begin
		cfg            = '0;
		cfg.dim        = dim_e;
		cfg.nx         = nx;
		cfg.ny         = ny;
		cfg.nz         = nz;
		cfg.row        = row_q;
		cfg.plane      = plane_q;
		cfg.elem_plane = ep_q;
		cfg.sx         = sx_q;
		cfg.sy         = sy_q;
		cfg.sz         = sz_q;
		cfg.sxsy       = sxsy_q;
		cfg.top        = top_q;
	end

endmodule

@@ hw/rtl/sgmg_pipe.sv @@
// Three-stage request pipeline: range check, index and position products, sums and volume.
module sgmg_pipe import sgmg_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  sgmg_cfg_t     cfg,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          op,
	input  logic [CW-1:0] coord_i,
	input  logic [CW-1:0] coord_j,
	input  logic [CW-1:0] coord_k,
	output logic          item_valid,
	input  logic          item_ready,
	output sgmg_item_t    item
);

	logic          err0;
	logic [HW-1:0] h0;
	logic          rdy1;
	logic          rdy2;
	logic          rdy3;

	logic          v_s1;
	logic          op_s1;
	logic          err_s1;
	logic [HW-1:0] h_s1;
	logic [CW-1:0] ci_s1;
	logic [CW-1:0] cj_s1;
	logic [CW-1:0] ck_s1;

	logic               v_s2;
	logic               op_s2;
	logic               err_s2;
	logic [HW-1:0]      h_s2;
	logic [CW-1:0]      ci_s2;
	logic [PW+CW-1:0]   kp_s2;
	logic [RW+CW-1:0]   jr_s2;
	logic [EW+CW-1:0]   ke_s2;
	logic [2*CW-1:0]    jn_s2;
	logic [XW-1:0]      px_s2;
	logic [XW-1:0]      py_s2;
	logic [XW-1:0]      pz_s2;

	logic          v_s3;
	logic          op_s3;
	logic          err_s3;
	logic [HW-1:0] h_s3;
	logic [NW-1:0] base_s3;
	logic [NW-1:0] elem_s3;
	logic [XW-1:0] px_s3;
	logic [XW-1:0] py_s3;
	logic [XW-1:0] pz_s3;

	logic [CW+SW-1:0] px_d;
	logic [CW+SW-1:0] py_d;
	logic [CW+SW-1:0] pz_d;
	logic [PW+CW-1:0] base_d;
	logic [EW+CW-1:0] elem_d;
	logic [DW-1:0]    v2;
	logic [DW-1:0]    v3;
	logic [VW-1:0]    vol;

	always_comb begin
		if (op == OP_NODE) begin
			err0 = (coord_i > cfg.nx) || (coord_j > cfg.ny) || (coord_k > cfg.nz);
		end else begin
			err0 = (coord_i >= cfg.nx)
				|| ((cfg.dim >= DIM_QUAD) ? (coord_j >= cfg.ny) : (coord_j != '0))
				|| ((cfg.dim == DIM_HEX) ? (coord_k >= cfg.nz) : (coord_k != '0));
		end
		h0 = HW'(coord_i == '0 || coord_i == cfg.nx)
			+ HW'(cfg.dim >= DIM_QUAD && (coord_j == '0 || coord_j == cfg.ny))
			+ HW'(cfg.dim == DIM_HEX && (coord_k == '0 || coord_k == cfg.nz));
	end

	assign rdy3     = !v_s3 || item_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	assign px_d = (CW+SW)'(ci_s1) * (CW+SW)'(cfg.sx);
	assign py_d = (CW+SW)'(cj_s1) * (CW+SW)'(cfg.sy);
	assign pz_d = (CW+SW)'(ck_s1) * (CW+SW)'(cfg.sz);

	assign base_d = kp_s2 + (PW+CW)'(jr_s2) + (PW+CW)'(ci_s2);
	assign elem_d = ke_s2 + (EW+CW)'(jn_s2) + (EW+CW)'(ci_s2);

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			op_s1  <= op;
			err_s1 <= err0;
			h_s1   <= h0;
			ci_s1  <= coord_i;
			cj_s1  <= coord_j;
			ck_s1  <= coord_k;
		end
		if (rdy2 && v_s1) begin
			op_s2  <= op_s1;
			err_s2 <= err_s1;
			h_s2   <= h_s1;
			ci_s2  <= ci_s1;
			kp_s2  <= (PW+CW)'(ck_s1) * (PW+CW)'(cfg.plane);
			jr_s2  <= (RW+CW)'(cj_s1) * (RW+CW)'(cfg.row);
			ke_s2  <= (EW+CW)'(ck_s1) * (EW+CW)'(cfg.elem_plane);
			jn_s2  <= (2*CW)'(cj_s1) * (2*CW)'(cfg.nx);
			px_s2  <= px_d[XW-1:0];
			py_s2  <= py_d[XW-1:0];
			pz_s2  <= pz_d[XW-1:0];
		end
		if (rdy3 && v_s2) begin
			op_s3   <= op_s2;
			err_s3  <= err_s2;
			h_s3    <= h_s2;
			base_s3 <= base_d[NW-1:0];
			elem_s3 <= elem_d[NW-1:0];
			px_s3   <= px_s2;
			py_s3   <= py_s2;
			pz_s3   <= pz_s2;
		end
	end

	assign v2 = (cfg.sxsy >> 16) >> h_s3;
	assign v3 = cfg.top >> h_s3;

	always_comb begin
		case (cfg.dim)
			DIM_LINE: vol = VW'(cfg.sx >> h_s3);
			DIM_QUAD: vol = v2[VW-1:0];
			default:  vol = (|v3[DW-1:VW]) ? '1 : v3[VW-1:0];
		endcase
	end

	assign item_valid = v_s3;

	always_comb begin
		item      = '0;
		item.err  = err_s3;
		item.op   = op_s3;
		item.base = base_s3;
		item.elem = elem_s3;
		item.px   = px_s3;
		item.py   = py_s3;
		item.pz   = pz_s3;
		item.vol  = vol;
	end

endmodule

@@ hw/rtl/sgmg_emit.sv @@
// Vertex expander and output register: one beat per node or error, 2, 4 or 8 per element.
module sgmg_emit import sgmg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  sgmg_cfg_t  cfg,
	input  logic       item_valid,
	output logic       item_ready,
	input  sgmg_item_t item,
	output logic       out_valid,
	input  logic       out_stall,
	output sgmg_beat_t beat
);

	logic           v_s4;
	sgmg_item_t     it_s4;
	logic [SLW-1:0] cnt_q;
	logic           ov_q;
	sgmg_beat_t     beat_q;

	logic [SLW-1:0] last_idx;
	logic           o_load;
	logic           fire;
	logic           beat_last;
	logic [NW-1:0]  vert;
	sgmg_beat_t     nxt;

	always_comb begin
		case (cfg.dim)
			DIM_LINE: last_idx = SLW'(1);
			DIM_QUAD: last_idx = SLW'(3);
			default:  last_idx = SLW'(7);
		endcase
	end

	assign o_load     = !ov_q || !out_stall;
	assign fire       = v_s4 && o_load;
	assign beat_last  = it_s4.err || (it_s4.op == OP_NODE) || (cnt_q == last_idx);
	assign item_ready = !v_s4 || (fire && beat_last);

	assign vert = it_s4.base
		+ NW'(cnt_q[0] ^ cnt_q[1])
		+ (cnt_q[1] ? NW'(cfg.row) : '0)
		+ (cnt_q[2] ? NW'(cfg.plane) : '0);

	always_comb begin
		nxt = '0;
		if (it_s4.err) begin
			nxt.error = 1'b1;
			nxt.last  = 1'b1;
		end else if (it_s4.op == OP_NODE) begin
			nxt.item_number = it_s4.base;
			nxt.node_index  = it_s4.base;
			nxt.pos_x       = it_s4.px;
			nxt.pos_y       = it_s4.py;
			nxt.pos_z       = it_s4.pz;
			nxt.volume      = it_s4.vol;
			nxt.last        = 1'b1;
		end else begin
			nxt.item_number = it_s4.elem;
			nxt.vertex_slot = cnt_q;
			nxt.node_index  = vert;
			nxt.last        = beat_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4  <= 1'b0;
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (item_ready) begin
				v_s4 <= item_valid;
			end
			if (fire) begin
				cnt_q <= beat_last ? '0 : cnt_q + SLW'(1);
			end
			if (o_load) begin
				ov_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			it_s4 <= item;
		end
		if (fire) begin
			beat_q <= nxt;
		end
	end

	assign out_valid = ov_q;
	assign beat      = beat_q;

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> cnt_q == '0)
		else $error("vertex counter not cleared between requests");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && beat_q.error |-> beat_q.last)
		else $error("error beat not marked last");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && it_s4.op == OP_ELEMENT && !it_s4.err |-> cnt_q <= last_idx)
		else $error("vertex slot beyond element size");

endmodule

@@ hw/rtl/structured_grid_mesh_generator_unit.sv @@
// Top level of the structured grid mesh generator.
// Each request beat names a node or an element of a uniform line, quad or hexahedral
// grid. A node or out-of-range request yields one result beat; an element yields 2, 4
// or 8 vertex beats, one per cycle while the output is not stalled, the final one
// marked last. A new request is taken whenever in_stall is low, also while earlier
// ones are still in flight; in_stall rises when the vertex expander backs up. Steps:
// range check, index and position products, index sums and volume selection, vertex
// expansion, output register. Write the registers only while no request is in
// flight; the block itself does not enforce it. The derived grid constants they
// feed settle in time for a request in the next cycle.
module structured_grid_mesh_generator_unit import sgmg_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_index,
	input  logic [SW-1:0] wr_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          op,
	input  logic [CW-1:0] coord_i,
	input  logic [CW-1:0] coord_j,
	input  logic [CW-1:0] coord_k,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          error,
	output logic [NW-1:0] item_number,
	output logic [SLW-1:0] vertex_slot,
	output logic [NW-1:0] node_index,
	output logic [XW-1:0] pos_x,
	output logic [XW-1:0] pos_y,
	output logic [XW-1:0] pos_z,
	output logic [VW-1:0] volume,
	output logic          last
);

	sgmg_cfg_t  cfg;
	logic       item_valid;
	logic       item_ready;
	sgmg_item_t item;
	sgmg_beat_t beat;

	sgmg_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	sgmg_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.coord_i    (coord_i),
		.coord_j    (coord_j),
		.coord_k    (coord_k),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	sgmg_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.beat       (beat)
	);

	assign error       = beat.error;
	assign item_number = beat.item_number;
	assign vertex_slot = beat.vertex_slot;
	assign node_index  = beat.node_index;
	assign pos_x       = beat.pos_x;
	assign pos_y       = beat.pos_y;
	assign pos_z       = beat.pos_z;
	assign volume      = beat.volume;
	assign last        = beat.last;

endmodule

@@ bench/structured_grid_mesh_generator_unit_checker.sv @@
// Grid generator checker: tracks register writes, predicts result beats and compares them.
module structured_grid_mesh_generator_unit_checker import sgmg_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [IW-1:0]  wr_index,
	input  logic [SW-1:0]  wr_data,
	input  logic           in_valid,
	input  logic           in_stall,
	input  logic           op,
	input  logic [CW-1:0]  coord_i,
	input  logic [CW-1:0]  coord_j,
	input  logic [CW-1:0]  coord_k,
	input  logic           out_valid,
	input  logic           out_stall,
	input  logic           error,
	input  logic [NW-1:0]  item_number,
	input  logic [SLW-1:0] vertex_slot,
	input  logic [NW-1:0]  node_index,
	input  logic [XW-1:0]  pos_x,
	input  logic [XW-1:0]  pos_y,
	input  logic [XW-1:0]  pos_z,
	input  logic [VW-1:0]  volume,
	input  logic           last,
	output int             mismatch_count,
	output int             beats_owed
);

	localparam logic [VW-1:0] VOLUME_FULL = '1;

	logic [1:0]    grid_dim;
	logic [CW-1:0] cells_x, cells_y, cells_z;
	logic [SW-1:0] spacing_x, spacing_y, spacing_z;
	sgmg_beat_t    owed_grid_beats[$];
	int            beats_seen;

	function automatic logic [63:0] cells_in_use(input logic [CW-1:0] c);
		logic [63:0] n;
		n = 64'(c);
		if (n == 0) begin
			n = 1;
		end else if (n > 64'(MAX_CELLS)) begin
			n = 64'(MAX_CELLS);
		end
		return n;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 40) begin
			$display("result beat %0d: %s", beats_seen, msg);
		end
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, want %0h", name, got, want));
		end
	endtask

	task automatic queue_request_beats(input logic kind, input logic [CW-1:0] ci,
			input logic [CW-1:0] cj, input logic [CW-1:0] ck);
		logic [1:0]  d;
		logic [63:0] nx, ny, nz, row, plane, base, elem, vertex;
		logic [95:0] product, vol;
		int          halvings, shift, count;
		logic        bad;
		sgmg_beat_t  beat;
		d = grid_dim;
		nx = cells_in_use(cells_x);
		ny = (d >= DIM_QUAD) ? cells_in_use(cells_y) : 64'd0;
		nz = (d == DIM_HEX) ? cells_in_use(cells_z) : 64'd0;
		if (d < DIM_LINE) begin
			d = DIM_LINE;
		end
		row = nx + 1;
		plane = row * (ny + 1);
		if (kind == OP_NODE) begin
			bad = ci > nx || cj > ny || ck > nz;
		end else begin
			bad = ci >= nx || (d >= DIM_QUAD ? cj >= ny : cj != 0) ||
				(d == DIM_HEX ? ck >= nz : ck != 0);
		end
		beat = '0;
		base = 64'(ck) * plane + 64'(cj) * row + 64'(ci);
		if (bad) begin
			beat.error = 1'b1;
			beat.last = 1'b1;
			owed_grid_beats = {owed_grid_beats, beat};
		end else if (kind == OP_NODE) begin
			halvings = 0;
			if (ci == 0 || ci == nx) begin
				halvings++;
			end
			if (d >= DIM_QUAD && (cj == 0 || cj == ny)) begin
				halvings++;
			end
			if (d == DIM_HEX && (ck == 0 || ck == nz)) begin
				halvings++;
			end
			product = 96'(spacing_x);
			shift = 0;
			if (d >= DIM_QUAD) begin
				product = product * 96'(spacing_y);
				shift = 16;
			end
			if (d == DIM_HEX) begin
				product = product * 96'(spacing_z);
				shift = 32;
			end
			vol = product >> (shift + halvings);
			beat.item_number = NW'(base);
			beat.node_index = NW'(base);
			beat.pos_x = XW'(64'(ci) * 64'(spacing_x));
			beat.pos_y = XW'(64'(cj) * 64'(spacing_y));
			beat.pos_z = XW'(64'(ck) * 64'(spacing_z));
			beat.volume = (vol > 96'(VOLUME_FULL)) ? VOLUME_FULL : VW'(vol);
			beat.last = 1'b1;
			owed_grid_beats = {owed_grid_beats, beat};
		end else begin
			elem = (64'(ck) * ((ny != 0) ? ny : 64'd1) + 64'(cj)) * nx + 64'(ci);
			count = (d == DIM_LINE) ? 2 : ((d == DIM_QUAD) ? 4 : 8);
			for (int s = 0; s < count; s++) begin
				vertex = base;
				if (s % 4 == 1 || s % 4 == 2) begin
					vertex += 1;
				end
				if (s % 4 >= 2) begin
					vertex += row;
				end
				if (s >= 4) begin
					vertex += plane;
				end
				beat = '0;
				beat.item_number = NW'(elem);
				beat.vertex_slot = SLW'(s);
				beat.node_index = NW'(vertex);
				beat.last = (s == count - 1);
				owed_grid_beats = {owed_grid_beats, beat};
			end
		end
	endtask

	task automatic check_result_beat();
		sgmg_beat_t want;
		if (owed_grid_beats.size() == 0) begin
			report_mismatch("arrived with no result owed");
		end else begin
			want = owed_grid_beats.pop_front();
			compare_field("error", 64'(error), 64'(want.error));
			compare_field("item_number", 64'(item_number), 64'(want.item_number));
			compare_field("vertex_slot", 64'(vertex_slot), 64'(want.vertex_slot));
			compare_field("node_index", 64'(node_index), 64'(want.node_index));
			compare_field("pos_x", 64'(pos_x), 64'(want.pos_x));
			compare_field("pos_y", 64'(pos_y), 64'(want.pos_y));
			compare_field("pos_z", 64'(pos_z), 64'(want.pos_z));
			compare_field("volume", 64'(volume), 64'(want.volume));
			compare_field("last", 64'(last), 64'(want.last));
		end
		beats_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_dim = DIM_QUAD;
			cells_x = CW'(1);
			cells_y = CW'(1);
			cells_z = CW'(1);
			spacing_x = SW'(65536);
			spacing_y = SW'(65536);
			spacing_z = SW'(65536);
			owed_grid_beats.delete();
			beats_seen = 0;
			mismatch_count = 0;
			beats_owed = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_DIMENSION: grid_dim = wr_data[1:0];
					REG_CELLS_X:   cells_x = wr_data[CW-1:0];
					REG_CELLS_Y:   cells_y = wr_data[CW-1:0];
					REG_CELLS_Z:   cells_z = wr_data[CW-1:0];
					REG_SPACING_X: spacing_x = wr_data;
					REG_SPACING_Y: spacing_y = wr_data;
					REG_SPACING_Z: spacing_z = wr_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				check_result_beat();
			end
			if (in_valid && !in_stall) begin
				queue_request_beats(op, coord_i, coord_j, coord_k);
			end
			beats_owed = owed_grid_beats.size();
		end
	end

endmodule

@@ bench/structured_grid_mesh_generator_unit_test.sv @@
// Grid generator testbench top: clock, reset, register setup, request stimulus and verdict.
module structured_grid_mesh_generator_unit_test;
	import sgmg_pkg::*;

	localparam int LONG_HOLD = 300;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           wr_en = 1'b0;
	logic [IW-1:0]  wr_index = '0;
	logic [SW-1:0]  wr_data = '0;
	logic           in_valid = 1'b0;
	logic           op = OP_NODE;
	logic [CW-1:0]  coord_i = '0;
	logic [CW-1:0]  coord_j = '0;
	logic [CW-1:0]  coord_k = '0;
	logic           out_stall = 1'b0;
	logic           in_stall;
	logic           out_valid;
	logic           error;
	logic [NW-1:0]  item_number;
	logic [SLW-1:0] vertex_slot;
	logic [NW-1:0]  node_index;
	logic [XW-1:0]  pos_x;
	logic [XW-1:0]  pos_y;
	logic [XW-1:0]  pos_z;
	logic [VW-1:0]  volume;
	logic           last;
	int             mismatch_count;
	int             beats_owed;

	int             gap_pct = 0;
	int             stall_pct = 0;
	int             hold_requests = 0;
	logic [1:0]     grid_dim = DIM_QUAD;
	logic [CW-1:0]  cells_x_now = CW'(1);
	logic [CW-1:0]  cells_y_now = CW'(1);
	logic [CW-1:0]  cells_z_now = CW'(1);

	structured_grid_mesh_generator_unit i_dut (.*);

	structured_grid_mesh_generator_unit_checker i_checker (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("structured_grid_mesh_generator_unit_test failed");
		$finish;
	end

	initial begin
		int hold_left;
		int hold_served;
		hold_left = 0;
		hold_served = 0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic send_request(input logic kind, input logic [CW-1:0] ci,
			input logic [CW-1:0] cj, input logic [CW-1:0] ck);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= kind;
		coord_i <= ci;
		coord_j <= cj;
		coord_k <= ck;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (beats_owed != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_register(input logic [IW-1:0] idx, input logic [SW-1:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
	endtask

	task automatic set_grid(input logic [1:0] d, input logic [CW-1:0] cx,
			input logic [CW-1:0] cy, input logic [CW-1:0] cz, input logic [SW-1:0] sx,
			input logic [SW-1:0] sy, input logic [SW-1:0] sz);
		write_register(REG_DIMENSION, SW'(d));
		write_register(REG_CELLS_X, SW'(cx));
		write_register(REG_CELLS_Y, SW'(cy));
		write_register(REG_CELLS_Z, SW'(cz));
		write_register(REG_SPACING_X, sx);
		write_register(REG_SPACING_Y, sy);
		write_register(REG_SPACING_Z, sz);
		wr_en <= 1'b0;
		grid_dim = d;
		cells_x_now = cx;
		cells_y_now = cy;
		cells_z_now = cz;
	endtask

	function automatic logic [CW-1:0] random_cells();
		int r;
		r = $urandom_range(99);
		if (r < 35) begin
			return CW'($urandom_range(4, 1));
		end else if (r < 55) begin
			return CW'($urandom_range(40, 5));
		end else if (r < 70) begin
			return CW'($urandom_range(1024, 41));
		end else if (r < 78) begin
			return MAX_CELLS;
		end else if (r < 84) begin
			return '0;
		end else if (r < 92) begin
			return CW'($urandom_range(2047, 1025));
		end
		return CW'(1);
	endfunction

	function automatic logic [SW-1:0] random_spacing();
		int r;
		r = $urandom_range(99);
		if (r < 10) begin
			return '0;
		end else if (r < 20) begin
			return '1;
		end else if (r < 35) begin
			return SW'(65536);
		end
		return SW'($urandom);
	endfunction

	function automatic logic [CW-1:0] pick_coord(input int limit);
		int r;
		r = $urandom_range(99);
		if (r < 15) begin
			return '0;
		end else if (r < 30) begin
			return CW'(limit);
		end
		return CW'($urandom_range(limit));
	endfunction

	task automatic send_random_request();
		int            nx, ny, nz, r;
		logic          kind;
		logic [CW-1:0] ci, cj, ck;
		nx = int'(eff_cells(cells_x_now));
		ny = (grid_dim >= DIM_QUAD) ? int'(eff_cells(cells_y_now)) : 0;
		nz = (grid_dim == DIM_HEX) ? int'(eff_cells(cells_z_now)) : 0;
		kind = 1'($urandom_range(1));
		r = $urandom_range(99);
		if (r < 12) begin
			ci = CW'($urandom);
			cj = CW'($urandom);
			ck = CW'($urandom);
		end else begin
			if (kind == OP_NODE) begin
				ci = pick_coord(nx);
				cj = pick_coord(ny);
				ck = pick_coord(nz);
			end else begin
				ci = pick_coord(nx - 1);
				cj = pick_coord((ny != 0) ? ny - 1 : 0);
				ck = pick_coord((nz != 0) ? nz - 1 : 0);
			end
			if (r < 22) begin
				case ($urandom_range(2))
					0: ci = CW'((kind == OP_NODE) ? nx + 1 : nx);
					1: cj = CW'((kind == OP_NODE) ? ny + 1 : ((ny != 0) ? ny : 1));
					default: ck = CW'((kind == OP_NODE) ? nz + 1 : ((nz != 0) ? nz : 1));
				endcase
			end
		end
		send_request(kind, ci, cj, ck);
	endtask

	initial begin
		int mode_gap[4];
		int mode_stall[4];
		mode_gap = '{0, 50, 0, 28};
		mode_stall = '{0, 0, 50, 28};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_request(OP_NODE, 0, 0, 0);
		send_request(OP_NODE, 1, 1, 0);
		send_request(OP_ELEMENT, 0, 0, 0);
		send_request(OP_NODE, 2, 0, 0);
		send_request(OP_ELEMENT, 0, 1, 0);
		wait_for_results();

		// full-size hexahedron, oversized and zero cell counts, widest spacings
		set_grid(DIM_HEX, MAX_CELLS, '1, '0, '1, '1, '1);
		send_request(OP_NODE, 1024, 1024, 1);
		send_request(OP_ELEMENT, 1023, 1023, 0);
		send_request(OP_NODE, '1, '1, '1);
		send_request(OP_ELEMENT, 0, 0, 1);
		send_request(OP_NODE, 512, 3, 0);
		wait_for_results();

		// dimension zero behaves as a line; nonzero unused axes must fail
		set_grid('0, 5, 1, 1, SW'(32'h0001_8000), '0, '0);
		send_request(OP_NODE, 5, 0, 0);
		send_request(OP_NODE, 2, 0, 0);
		send_request(OP_ELEMENT, 4, 0, 0);
		send_request(OP_ELEMENT, 0, 1, 0);
		send_request(OP_NODE, 0, 0, 1);
		wait_for_results();

		set_grid(DIM_HEX, 3, 4, 2, '0, SW'(65536), SW'(32'h7FFF_FFFF));
		send_request(OP_NODE, 1, 2, 1);
		send_request(OP_ELEMENT, 2, 3, 1);
		send_request(OP_NODE, 3, 4, 2);
		send_request(OP_ELEMENT, 0, 0, 0);
		wait_for_results();

		set_grid(DIM_LINE, MAX_CELLS, 7, 7, '1, '0, '0);
		send_request(OP_NODE, 1024, 0, 0);
		send_request(OP_ELEMENT, 1023, 0, 0);
		wait_for_results();

		for (int m = 0; m < 4; m++) begin
			gap_pct = mode_gap[m];
			stall_pct = mode_stall[m];
			for (int p = 0; p < 2; p++) begin
				set_grid(2'($urandom_range(3)), random_cells(), random_cells(),
					random_cells(), random_spacing(), random_spacing(), random_spacing());
				repeat (36) send_random_request();
				wait_for_results();
			end
		end

		// hold off the output long enough to back the block up into its input
		gap_pct = 0;
		stall_pct = 0;
		set_grid(DIM_HEX, 2, 2, 2, random_spacing(), random_spacing(), random_spacing());
		hold_requests++;
		repeat (30) send_random_request();
		wait_for_results();

		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && beats_owed == 0) begin
			$display("structured_grid_mesh_generator_unit_test passed");
		end else begin
			$display("structured_grid_mesh_generator_unit_test failed");
		end
		$finish;
	end

endmodule
